// ===== hdl/sfd_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the stuffed frame deframer.
// Used by sfd_cfg, sfd_deframe and stuffed_frame_deframer_crc16; depends on nothing.
package sfd_pkg;

    localparam int COUNT_BITS = 8;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam int CFG_ADDR_BITS = 5;

    typedef enum logic [2:0] {
        REG_HEADER     = 3'd0,
        REG_TERMINATOR = 3'd1,
        REG_ESCAPE     = 3'd2,
        REG_ESC_OFFSET = 3'd3,
        REG_STATUS_POS = 3'd4,
        REG_CMD_POS    = 3'd5,
        REG_VALUE_POS  = 3'd6,
        REG_MIN_LEN    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_CRC   = 2'd2
    } frame_err_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] terminator_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_offset;
        logic [7:0] status_position;
        logic [7:0] command_position;
        logic [7:0] value_position;
        logic [7:0] min_frame_length;
    } cfg_t;

    typedef struct packed {
        logic       frame_valid;
        frame_err_t frame_error;
        logic [7:0] status_out;
        logic [7:0] command_out;
        logic [7:0] value_out;
    } result_t;

    // CRC-16 XMODEM update over one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/sfd_cfg.sv =====
// APB-style register file for the deframer settings.
// Depends on sfd_pkg for the register indexes and the settings struct.
module sfd_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output sfd_pkg::cfg_t                     cfg
);

    sfd_pkg::cfg_t    cfg_reg;
    sfd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = sfd_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte      <= 8'd2;
            cfg_reg.terminator_byte  <= 8'd3;
            cfg_reg.escape_byte      <= 8'd16;
            cfg_reg.escape_offset    <= 8'd32;
            cfg_reg.status_position  <= 8'd1;
            cfg_reg.command_position <= 8'd2;
            cfg_reg.value_position   <= 8'd3;
            cfg_reg.min_frame_length <= 8'd6;
        end
        else if (wr_en)
        begin
            unique case (idx)
                sfd_pkg::REG_HEADER:     cfg_reg.header_byte      <= pwdata[7:0];
                sfd_pkg::REG_TERMINATOR: cfg_reg.terminator_byte  <= pwdata[7:0];
                sfd_pkg::REG_ESCAPE:     cfg_reg.escape_byte      <= pwdata[7:0];
                sfd_pkg::REG_ESC_OFFSET: cfg_reg.escape_offset    <= pwdata[7:0];
                sfd_pkg::REG_STATUS_POS: cfg_reg.status_position  <= pwdata[7:0];
                sfd_pkg::REG_CMD_POS:    cfg_reg.command_position <= pwdata[7:0];
                sfd_pkg::REG_VALUE_POS:  cfg_reg.value_position   <= pwdata[7:0];
                sfd_pkg::REG_MIN_LEN:    cfg_reg.min_frame_length <= pwdata[7:0];
                default:                 cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sfd_pkg::REG_HEADER:     prdata = {24'd0, cfg_reg.header_byte};
            sfd_pkg::REG_TERMINATOR: prdata = {24'd0, cfg_reg.terminator_byte};
            sfd_pkg::REG_ESCAPE:     prdata = {24'd0, cfg_reg.escape_byte};
            sfd_pkg::REG_ESC_OFFSET: prdata = {24'd0, cfg_reg.escape_offset};
            sfd_pkg::REG_STATUS_POS: prdata = {24'd0, cfg_reg.status_position};
            sfd_pkg::REG_CMD_POS:    prdata = {24'd0, cfg_reg.command_position};
            sfd_pkg::REG_VALUE_POS:  prdata = {24'd0, cfg_reg.value_position};
            sfd_pkg::REG_MIN_LEN:    prdata = {24'd0, cfg_reg.min_frame_length};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/sfd_deframe.sv =====
// Frame state, unstuffing, CRC-16 and field capture for one wire byte per cycle while byte_en is high.
// Depends on sfd_pkg for the settings and result structs and the CRC function.
module sfd_deframe (
    input  logic             clk,
    input  logic             rst_n,
    input  sfd_pkg::cfg_t    cfg,
    input  logic             byte_en,
    input  logic [7:0]       wire_byte,
    output logic             emit,
    output sfd_pkg::result_t result
);

    localparam int CNT_W = sfd_pkg::COUNT_BITS;
    localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    logic             inside_reg,  inside_next;
    logic             esc_reg,     esc_next;
    logic [15:0]      crc_reg,     crc_next;
    logic [7:0]       tail0_reg,   tail0_next;
    logic [7:0]       tail1_reg,   tail1_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [7:0]       status_reg,  status_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       value_reg,   value_next;

    logic             push;
    logic [7:0]       push_data;
    logic [15:0]      base_crc;
    logic [7:0]       base_tail0;
    logic [7:0]       base_tail1;
    logic [CNT_W-1:0] base_cnt;
    logic [7:0]       base_status;
    logic [7:0]       base_command;
    logic [7:0]       base_value;
    logic             too_short;
    logic             crc_bad;

    always_comb
    begin
        inside_next  = inside_reg;
        esc_next     = esc_reg;
        crc_next     = crc_reg;
        tail0_next   = tail0_reg;
        tail1_next   = tail1_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        command_next = command_reg;
        value_next   = value_reg;
        push         = 1'b0;
        push_data    = wire_byte;
        emit         = 1'b0;
        base_crc     = crc_reg;
        base_tail0   = tail0_reg;
        base_tail1   = tail1_reg;
        base_cnt     = cnt_reg;
        base_status  = status_reg;
        base_command = command_reg;
        base_value   = value_reg;

        if (byte_en)
        begin
            if (!inside_reg)
            begin
                // open on header, starting from a cleared frame
                if (wire_byte == cfg.header_byte)
                begin
                    inside_next  = 1'b1;
                    esc_next     = 1'b0;
                    push         = 1'b1;
                    base_crc     = sfd_pkg::CRC_INIT;
                    base_tail0   = 8'd0;
                    base_tail1   = 8'd0;
                    base_cnt     = '0;
                    base_status  = 8'd0;
                    base_command = 8'd0;
                    base_value   = 8'd0;
                end
            end
            else if (esc_reg)
            begin
                esc_next  = 1'b0;
                push      = 1'b1;
                push_data = wire_byte + cfg.escape_offset;
            end
            else if (wire_byte == cfg.escape_byte)
            begin
                esc_next = 1'b1;
            end
            else if (wire_byte != cfg.terminator_byte)
            begin
                push = 1'b1;
            end
            else
            begin
                // close the frame and drop all per-frame state
                emit         = 1'b1;
                inside_next  = 1'b0;
                esc_next     = 1'b0;
                crc_next     = sfd_pkg::CRC_INIT;
                tail0_next   = 8'd0;
                tail1_next   = 8'd0;
                cnt_next     = '0;
                status_next  = 8'd0;
                command_next = 8'd0;
                value_next   = 8'd0;
            end
        end

        if (push)
        begin
            // the byte leaving the two-byte tail enters the CRC
            crc_next     = (base_cnt >= CNT_TWO) ? sfd_pkg::crc16_byte(base_crc, base_tail0)
                                                 : base_crc;
            tail0_next   = base_tail1;
            tail1_next   = push_data;
            cnt_next     = base_cnt;
            status_next  = base_status;
            command_next = base_command;
            value_next   = base_value;
            if (base_cnt != CNT_MAX)
            begin
                if (CW'(base_cnt) == CW'(cfg.status_position))
                begin
                    status_next = push_data;
                end
                if (CW'(base_cnt) == CW'(cfg.command_position))
                begin
                    command_next = push_data;
                end
                if (CW'(base_cnt) == CW'(cfg.value_position))
                begin
                    value_next = push_data;
                end
                cnt_next = base_cnt + CNT_W'(1);
            end
        end
    end

    assign too_short = (cnt_reg < CNT_TWO) || (CW'(cnt_reg) < CW'(cfg.min_frame_length));
    assign crc_bad   = ({tail0_reg, tail1_reg} != crc_reg);

    always_comb
    begin
        result.frame_valid = 1'b0;
        result.frame_error = sfd_pkg::ERR_NONE;
        result.status_out  = 8'd0;
        result.command_out = 8'd0;
        result.value_out   = 8'd0;
        if (too_short)
        begin
            result.frame_error = sfd_pkg::ERR_SHORT;
        end
        else if (crc_bad)
        begin
            result.frame_error = sfd_pkg::ERR_CRC;
        end
        else
        begin
            result.frame_valid = 1'b1;
            result.status_out  = status_reg;
            result.command_out = command_reg;
            result.value_out   = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            crc_reg     <= sfd_pkg::CRC_INIT;
            tail0_reg   <= 8'd0;
            tail1_reg   <= 8'd0;
            cnt_reg     <= '0;
            status_reg  <= 8'd0;
            command_reg <= 8'd0;
            value_reg   <= 8'd0;
        end
        else
        begin
            inside_reg  <= inside_next;
            esc_reg     <= esc_next;
            crc_reg     <= crc_next;
            tail0_reg   <= tail0_next;
            tail1_reg   <= tail1_next;
            cnt_reg     <= cnt_next;
            status_reg  <= status_next;
            command_reg <= command_next;
            value_reg   <= value_next;
        end
    end

`ifndef SYNTH
    a_esc_inside: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> inside_reg)
        else $error("escape pending outside a frame");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_reg |-> (cnt_reg == '0 && crc_reg == sfd_pkg::CRC_INIT))
        else $error("frame state not cleared while idle");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !inside_reg && cnt_reg == '0)
        else $error("frame still open after a result");
`endif

endmodule

// ===== hdl/stuffed_frame_deframer_crc16.sv =====
// Top level of the byte-stuffed frame deframer with CRC-16 check.
// Depends on sfd_pkg, sfd_cfg and sfd_deframe.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_*       | in        | tdata[7:0] wire_byte
//  m_*       | out       | tuser[0] frame_valid, tuser[2:1] frame_error;
//            |           | tdata status_out, command_out, value_out
//  APB       | in/out    | eight 8-bit settings at byte addresses 0..28
//
// Each wire byte updates the frame state in the cycle it is accepted, and a
// closing terminator loads the result register at that edge.
// One byte per cycle is sustained while m_tready is high; the single result
// register sets the rate under back-pressure, since a new byte is taken
// whenever that register is empty or is being drained in the same cycle.
// Reset clears the frame state and the valid flag of the result register
// (not its contents) and loads the default settings; no clearing pass follows.
module stuffed_frame_deframer_crc16 (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // wire byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] wire_byte
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [7:0] status_out, [15:8] command_out,
                                                         // [23:16] value_out
    output logic [2:0]                        m_tuser    // [0] frame_valid, [2:1] frame_error
);

    sfd_pkg::cfg_t    cfg;
    sfd_pkg::result_t result;
    sfd_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             byte_en;
    logic             emit;

    sfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // take a byte when the result register is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign byte_en  = s_tvalid && s_tready;

    sfd_deframe u_deframe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .byte_en   (byte_en),
        .wire_byte (s_tdata),
        .emit      (emit),
        .result    (result)
    );

    // result register: load on a closing terminator, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value_out, out_reg.command_out, out_reg.status_out};
    assign m_tuser  = {out_reg.frame_error, out_reg.frame_valid};

`ifndef SYNTH
    a_valid_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tuser[2:1] == sfd_pkg::ERR_NONE)
        else $error("valid frame reported with an error code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 24'd0 && m_tuser[2:1] != sfd_pkg::ERR_NONE))
        else $error("rejected frame carries data or no error code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for stuffed_frame_deframer_crc16: a shadow deframer predicts each
// frame result from the accepted wire bytes, and a checker compares every result stream
// transaction with it. Depends on sfd_pkg and the deframer RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] octet_t;
    typedef octet_t octet_q_t[$];

    localparam int COUNT_FULL  = (1 << sfd_pkg::COUNT_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;

    logic                              clk     = 1'b0;
    logic                              rst_n   = 1'b0;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [sfd_pkg::CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]                       pwdata  = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [23:0]                       m_tdata;
    logic [2:0]                        m_tuser;

    // Settings the shadow deframer works with; starts at the reset values of the block
    sfd_pkg::cfg_t shadow_cfg = '{header_byte: 8'd2, terminator_byte: 8'd3, escape_byte: 8'd16,
                                  escape_offset: 8'd32, status_position: 8'd1,
                                  command_position: 8'd2, value_position: 8'd3,
                                  min_frame_length: 8'd6};

    // Shadow frame state
    logic                           in_frame    = 1'b0;
    logic                           esc_pending = 1'b0;
    logic [15:0]                    frame_crc   = sfd_pkg::CRC_INIT;
    octet_t                         tail_old    = '0;
    octet_t                         tail_new    = '0;
    logic [sfd_pkg::COUNT_BITS-1:0] frame_count = '0;
    octet_t                         held_status = '0;
    octet_t                         held_cmd    = '0;
    octet_t                         held_value  = '0;

    // Frame results still owed by the block, oldest first
    sfd_pkg::result_t pending_frames[$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    stuffed_frame_deframer_crc16 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow deframer
    // ------------------------------------------------------------------

    // CRC-16 XMODEM, one message bit at a time, MSB first
    function automatic logic [15:0] xmodem_crc_step(input logic [15:0] crc, input octet_t d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? sfd_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic string fmt_result(input sfd_pkg::result_t r);
        return $sformatf("valid=%0d err=%0d status=%02h cmd=%02h value=%02h",
                         r.frame_valid, r.frame_error, r.status_out, r.command_out,
                         r.value_out);
    endfunction

    task automatic clear_frame();
        esc_pending = 1'b0;
        frame_crc   = sfd_pkg::CRC_INIT;
        tail_old    = '0;
        tail_new    = '0;
        frame_count = '0;
        held_status = '0;
        held_cmd    = '0;
        held_value  = '0;
    endtask

    // Append one logical byte: the byte leaving the two-byte tail enters the CRC,
    // and the capture positions are matched until the count saturates.
    task automatic push_logical(input octet_t d);
        if (frame_count >= 2)
            frame_crc = xmodem_crc_step(frame_crc, tail_old);
        tail_old = tail_new;
        tail_new = d;
        if (frame_count < COUNT_FULL)
        begin
            if (frame_count == shadow_cfg.status_position)
                held_status = d;
            if (frame_count == shadow_cfg.command_position)
                held_cmd = d;
            if (frame_count == shadow_cfg.value_position)
                held_value = d;
            frame_count++;
        end
    endtask

    // Advance the shadow deframer by one accepted wire byte and queue the
    // frame result that a closing terminator produces.
    task automatic deframe_wire_byte(input octet_t b);
        sfd_pkg::result_t r;
        if (!in_frame)
        begin
            // idle: only the header byte does anything
            if (b == shadow_cfg.header_byte)
            begin
                clear_frame();
                in_frame = 1'b1;
                push_logical(b);
            end
        end
        else if (esc_pending)
        begin
            // escaped byte is always data, terminator included
            esc_pending = 1'b0;
            push_logical(b + shadow_cfg.escape_offset);
        end
        else if (b == shadow_cfg.escape_byte)
            esc_pending = 1'b1;
        else if (b != shadow_cfg.terminator_byte)
            push_logical(b);
        else
        begin
            in_frame = 1'b0;
            r = '0;
            r.frame_error = sfd_pkg::ERR_NONE;
            // fewer than two logical bytes means no CRC bytes at all
            if (frame_count < 2 || frame_count < shadow_cfg.min_frame_length)
                r.frame_error = sfd_pkg::ERR_SHORT;
            else if ({tail_old, tail_new} != frame_crc)
                r.frame_error = sfd_pkg::ERR_CRC;
            else
            begin
                r.frame_valid = 1'b1;
                r.status_out  = held_status;
                r.command_out = held_cmd;
                r.value_out   = held_value;
            end
            pending_frames.push_back(r);
            clear_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transaction, then choose next cycle's tready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sfd_pkg::result_t want;
        sfd_pkg::result_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.frame_valid = m_tuser[0];
                got.frame_error = sfd_pkg::frame_err_t'(m_tuser[2:1]);
                got.status_out  = m_tdata[7:0];
                got.command_out = m_tdata[15:8];
                got.value_out   = m_tdata[23:16];
                if (pending_frames.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected frame result: expected none, actual %s",
                             $time, fmt_result(got));
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: frame result mismatch: expected %s, actual %s",
                                 $time, fmt_result(want), fmt_result(got));
                    end
                end
            end
            // a long hold-off lets the result register fill and stall the input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one wire byte, with random idle cycles ahead of it; hold tvalid
    // high on return so back-to-back bytes leave no gap.
    task automatic send_byte(input octet_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_wire_byte(b);
    endtask

    // Drop tvalid and wait until every owed frame result has come out
    task automatic pause_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write; psel stays high so writes can follow back to back
    task automatic write_reg(input sfd_pkg::reg_idx_t idx, input octet_t val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            sfd_pkg::REG_HEADER:     shadow_cfg.header_byte      = val;
            sfd_pkg::REG_TERMINATOR: shadow_cfg.terminator_byte  = val;
            sfd_pkg::REG_ESCAPE:     shadow_cfg.escape_byte      = val;
            sfd_pkg::REG_ESC_OFFSET: shadow_cfg.escape_offset    = val;
            sfd_pkg::REG_STATUS_POS: shadow_cfg.status_position  = val;
            sfd_pkg::REG_CMD_POS:    shadow_cfg.command_position = val;
            sfd_pkg::REG_VALUE_POS:  shadow_cfg.value_position   = val;
            sfd_pkg::REG_MIN_LEN:    shadow_cfg.min_frame_length = val;
            default: ;
        endcase
    endtask

    // Drain the block, then load all eight settings
    task automatic program_regs(input sfd_pkg::cfg_t c);
        pause_stream();
        write_reg(sfd_pkg::REG_HEADER,     c.header_byte);
        write_reg(sfd_pkg::REG_TERMINATOR, c.terminator_byte);
        write_reg(sfd_pkg::REG_ESCAPE,     c.escape_byte);
        write_reg(sfd_pkg::REG_ESC_OFFSET, c.escape_offset);
        write_reg(sfd_pkg::REG_STATUS_POS, c.status_position);
        write_reg(sfd_pkg::REG_CMD_POS,    c.command_position);
        write_reg(sfd_pkg::REG_VALUE_POS,  c.value_position);
        write_reg(sfd_pkg::REG_MIN_LEN,    c.min_frame_length);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Send header, body and its CRC (escaped where needed or at random), then
    // the terminator. Returns the number of wire bytes sent.
    task automatic send_frame(input octet_q_t body, input bit bad_crc, input int esc_pct,
                              output int nbytes);
        logic [15:0] crc;
        octet_q_t    lg;
        octet_t      b;
        crc = xmodem_crc_step(sfd_pkg::CRC_INIT, shadow_cfg.header_byte);
        foreach (body[i])
            crc = xmodem_crc_step(crc, body[i]);
        if (bad_crc)
            crc ^= 16'h0001 << $urandom_range(15);
        lg = body;
        lg.push_back(crc[15:8]);
        lg.push_back(crc[7:0]);
        send_byte(shadow_cfg.header_byte);
        nbytes = 1;
        foreach (lg[i])
        begin
            b = lg[i];
            if (b == shadow_cfg.escape_byte || b == shadow_cfg.terminator_byte ||
                $urandom_range(99) < esc_pct)
            begin
                send_byte(shadow_cfg.escape_byte);
                send_byte(b - shadow_cfg.escape_offset);
                nbytes += 2;
            end
            else
            begin
                send_byte(b);
                nbytes++;
            end
        end
        send_byte(shadow_cfg.terminator_byte);
        nbytes++;
    endtask

    // Body bytes, biased toward the special byte values
    function automatic octet_q_t random_body(input int len);
        octet_q_t q;
        int       r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 6)
                q.push_back(shadow_cfg.header_byte);
            else if (r < 12)
                q.push_back(shadow_cfg.escape_byte);
            else if (r < 18)
                q.push_back(shadow_cfg.terminator_byte);
            else
                q.push_back(octet_t'($urandom_range(255)));
        end
        return q;
    endfunction

    // Random settings; escape never equals terminator, or no frame could close
    function automatic sfd_pkg::cfg_t random_cfg();
        sfd_pkg::cfg_t c;
        c.header_byte     = octet_t'($urandom_range(255));
        c.terminator_byte = octet_t'($urandom_range(255));
        do
            c.escape_byte = octet_t'($urandom_range(255));
        while (c.escape_byte == c.terminator_byte);
        if ($urandom_range(3) == 0 && c.header_byte != c.terminator_byte)
            c.escape_byte = c.header_byte;
        c.escape_offset    = octet_t'($urandom_range(255));
        c.status_position  = octet_t'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                : $urandom_range(15));
        c.command_position = octet_t'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                : $urandom_range(15));
        c.value_position   = octet_t'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                : $urandom_range(15));
        c.min_frame_length = octet_t'($urandom_range(14, 2));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: idle noise, good and bad CRC, escaped terminator,
    // mid-frame header, and frames too short to carry a CRC.
    task automatic test_default_frames();
        int n;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_frame('{8'h03, 8'h10, 8'h02, 8'hC4}, 1'b0, 0, n);
        send_frame('{8'h03, 8'h10, 8'h02, 8'hC4}, 1'b1, 0, n);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h02);
        send_byte(8'h55);
        send_byte(8'h66);
        send_byte(8'h03);
    endtask

    // Escape equal to header, then escape equal to terminator (the terminator
    // only starts escapes) until a new escape byte lets it close the frame.
    task automatic test_special_bytes();
        sfd_pkg::cfg_t c;
        int            n;
        c = '{header_byte: 8'h7E, terminator_byte: 8'h7D, escape_byte: 8'h7E,
              escape_offset: 8'hFF, status_position: 8'd1, command_position: 8'd2,
              value_position: 8'd3, min_frame_length: 8'd4};
        program_regs(c);
        send_frame('{8'h7E, 8'h7D, 8'h01}, 1'b0, 0, n);
        send_byte(8'h13);
        c.escape_byte = 8'h7D;
        program_regs(c);
        send_byte(8'h7E);
        send_byte(8'h11);
        send_byte(8'h7D);
        send_byte(8'h7D);
        send_byte(8'h22);
        c.escape_byte = 8'h55;
        program_regs(c);
        send_byte(8'h7D);
    endtask

    // Extreme settings, a frame of just header and one byte, a long frame that
    // saturates the count, and capture positions near and at saturation.
    task automatic test_config_extremes();
        sfd_pkg::cfg_t c;
        int            n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        c = '{header_byte: 8'h00, terminator_byte: 8'hFF, escape_byte: 8'h00,
              escape_offset: 8'hFF, status_position: 8'd0, command_position: 8'd254,
              value_position: 8'd255, min_frame_length: 8'd2};
        program_regs(c);
        // header, escaped zero, terminator: two logical bytes, CRC of nothing
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        c = '{header_byte: 8'hFF, terminator_byte: 8'h00, escape_byte: 8'hFF,
              escape_offset: 8'h00, status_position: 8'd255, command_position: 8'd0,
              value_position: 8'd1, min_frame_length: 8'd255};
        program_regs(c);
        // 256 logical bytes: the count stops at 255 and the CRC runs on past it
        send_frame(random_body(253), 1'b0, 5, n);
        // far below the minimum length
        send_frame(random_body(8), 1'b0, 0, n);
    endtask

    // One phase of random traffic under one setting and idle mix: mostly
    // well-formed frames, some broken ones and idle noise.
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int target,
                                    input bit long_hold);
        int     sent;
        int     n;
        int     r;
        int     k;
        program_regs(random_cfg());
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_left = 400;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                // idle noise, ignored unless it happens to be the header
                k = $urandom_range(3, 1);
                repeat (k) send_byte(octet_t'($urandom_range(255)));
                sent += k;
            end
            else if (r < 18)
            begin
                // broken frame: random bytes, terminator present or not
                send_byte(shadow_cfg.header_byte);
                k = $urandom_range(6);
                repeat (k) send_byte(octet_t'($urandom_range(255)));
                if ($urandom_range(3) != 0)
                    send_byte(shadow_cfg.terminator_byte);
                sent += k + 2;
            end
            else
            begin
                k = ($urandom_range(24) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
                send_frame(random_body(k), $urandom_range(5) == 0, 10, n);
                sent += n;
            end
            if ($urandom_range(39) == 0)
                pause_stream();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 95, 1'b1);
        run_random_phase(45, 0, 95, 1'b0);
        run_random_phase(0, 45, 95, 1'b0);
        run_random_phase(34, 34, 95, 1'b0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frames();
        test_special_bytes();
        test_config_extremes();
        test_random_traffic();

        // let every owed result drain, then watch for strays
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
